// ===== hdl/lot_pkg.sv =====
// Shared types and constants for the LRU order tracker.
package lot_pkg;

    localparam int ID_W          = 8;
    localparam int ID_SPACE      = 1 << ID_W;
    localparam int CNT_W         = 9;
    localparam int MAX_IDS_DEF   = 256;
    localparam logic [CNT_W-1:0] CAPACITY_RESET = 9'd256;

    typedef enum logic [1:0] {
        OP_TOUCH  = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_POP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK          = 2'd0,
        STS_NOT_PRESENT = 2'd1,
        STS_EMPTY       = 2'd2,
        STS_ALREADY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        STATE_IDLE,
        STATE_UNLINK,
        STATE_LINK,
        STATE_HOLD
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic unlink;
        logic link;
        logic load;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

// ===== hdl/lru_order_tracker.sv =====
// Top level of the LRU order tracker: controller plus datapath.
//
// Keeps ids in recency order as a doubly linked list (most recent at head).
// Request channel: in_valid / in_stall with opcode and item_id; a request is
// transferred at a clock edge with in_valid high and in_stall low.
// Opcodes: touch, insert (evicts the oldest id when full), remove, pop oldest.
// Result channel: out_valid / out_stall with status, evicted, result_id and
// occupancy; exactly one result per request, in request order.
// A request passes through the transfer (link tables read), an unlink step and
// a link step, each with at most one write per link table; in_stall is high
// until the result is loaded. A single result register holds a finished result;
// if it is still stalled when the next result is ready, the block holds
// in_stall high until it drains. The user must write capacity via cfg_wr_en /
// cfg_wr_data only while the block is idle; the block does not enforce it.
// Reset empties the list, clears every presence bit and sets capacity to 256;
// the link tables are not cleared, as only links of listed ids are ever used.
module lru_order_tracker
#(
    parameter int MAX_IDS = lot_pkg::MAX_IDS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [lot_pkg::CNT_W-1:0] cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                opcode,
    input  logic [lot_pkg::ID_W-1:0]  item_id,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                status,
    output logic                      evicted,
    output logic [lot_pkg::ID_W-1:0]  result_id,
    output logic [lot_pkg::CNT_W-1:0] occupancy
);

    lot_pkg::cmd_t cmd;
    lot_pkg::sts_t sts;

    lot_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    lot_datapath
    #(
        .MAX_IDS (MAX_IDS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .opcode      (opcode),
        .item_id     (item_id),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .evicted     (evicted),
        .result_id   (result_id),
        .occupancy   (occupancy)
    );

endmodule

// ===== hdl/lot_ctrl.sv =====
// Sequencing controller for the LRU order tracker.
module lot_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  lot_pkg::sts_t sts,
    output lot_pkg::cmd_t cmd
);

    lot_pkg::state_t state_reg;
    lot_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lot_pkg::STATE_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lot_pkg::STATE_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lot_pkg::STATE_UNLINK;
                end
            end
            lot_pkg::STATE_UNLINK:
            begin
                state_next = lot_pkg::STATE_LINK;
            end
            lot_pkg::STATE_LINK:
            begin
                state_next = sts.out_free ? lot_pkg::STATE_IDLE : lot_pkg::STATE_HOLD;
            end
            lot_pkg::STATE_HOLD:
            begin
                if (sts.out_free)
                begin
                    state_next = lot_pkg::STATE_IDLE;
                end
            end
            default:
            begin
                state_next = lot_pkg::STATE_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            lot_pkg::STATE_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            lot_pkg::STATE_UNLINK:
            begin
                cmd.unlink = 1'b1;
            end
            lot_pkg::STATE_LINK:
            begin
                cmd.link = 1'b1;
                cmd.load = sts.out_free;
            end
            lot_pkg::STATE_HOLD:
            begin
                cmd.load = sts.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== hdl/lot_datapath.sv =====
// Link tables, presence bits, list registers and result register.
module lot_datapath
#(
    parameter int MAX_IDS = lot_pkg::MAX_IDS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  lot_pkg::cmd_t             cmd,
    output lot_pkg::sts_t             sts,
    input  logic                      cfg_wr_en,
    input  logic [lot_pkg::CNT_W-1:0] cfg_wr_data,
    input  logic [1:0]                opcode,
    input  logic [lot_pkg::ID_W-1:0]  item_id,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                status,
    output logic                      evicted,
    output logic [lot_pkg::ID_W-1:0]  result_id,
    output logic [lot_pkg::CNT_W-1:0] occupancy
);

    localparam int NUM_IDS = (MAX_IDS < lot_pkg::ID_SPACE) ? MAX_IDS : lot_pkg::ID_SPACE;
    localparam int IDX_W   = $clog2(NUM_IDS);
    localparam int CNT_W   = lot_pkg::CNT_W;
    localparam int ID_W    = lot_pkg::ID_W;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Link tables
    idx_t prev_mem [NUM_IDS];
    idx_t next_mem [NUM_IDS];
    idx_t rd_prev_reg;
    idx_t rd_next_reg;

    logic prev_we;
    idx_t prev_waddr;
    idx_t prev_wdata;
    logic next_we;
    idx_t next_waddr;
    idx_t next_wdata;

    // List state
    logic [NUM_IDS-1:0] present_reg;
    logic [NUM_IDS-1:0] present_next;
    idx_t               head_reg;
    idx_t               head_next;
    idx_t               tail_reg;
    idx_t               tail_next;
    cnt_t               count_reg;
    cnt_t               count_next;
    cnt_t               capacity_reg;
    cnt_t               cap_eff;

    // Plan worked out when the request is taken
    logic               plan_unlink_reg;
    logic               plan_link_reg;
    idx_t               tgt_reg;
    idx_t               idx_reg;
    lot_pkg::status_t   status_reg;
    logic               evict_reg;
    logic [ID_W-1:0]    rid_reg;

    idx_t               in_idx;
    logic               id_ok;
    logic               here;
    logic               p_unlink;
    logic               p_link;
    logic               p_evict;
    idx_t               p_tgt;
    lot_pkg::status_t   p_status;

    // Result register
    logic               out_valid_reg;
    logic [1:0]         status_out_reg;
    logic               evicted_out_reg;
    logic [ID_W-1:0]    rid_out_reg;
    cnt_t               occ_out_reg;

    assign sts.out_free = !out_valid_reg || !out_stall;

    assign cap_eff = (capacity_reg == '0) ? cnt_t'(1) : capacity_reg;
    assign in_idx  = idx_t'(item_id);
    assign id_ok   = cnt_t'(item_id) < cnt_t'(NUM_IDS);
    assign here    = id_ok && present_reg[in_idx];

    always_comb
    begin
        p_status = lot_pkg::STS_OK;
        p_unlink = 1'b0;
        p_link   = 1'b0;
        p_evict  = 1'b0;
        p_tgt    = in_idx;
        case (lot_pkg::op_t'(opcode))
            lot_pkg::OP_TOUCH:
            begin
                if (!here)
                begin
                    p_status = lot_pkg::STS_NOT_PRESENT;
                end
                else if (in_idx != head_reg)
                begin
                    p_unlink = 1'b1;
                    p_link   = 1'b1;
                end
            end
            lot_pkg::OP_INSERT:
            begin
                if (!id_ok)
                begin
                    p_status = lot_pkg::STS_NOT_PRESENT;
                end
                else if (here)
                begin
                    p_status = lot_pkg::STS_ALREADY;
                end
                else
                begin
                    p_link = 1'b1;
                    // full: drop the least recent id first
                    if (count_reg >= cap_eff)
                    begin
                        p_evict  = 1'b1;
                        p_unlink = 1'b1;
                        p_tgt    = tail_reg;
                    end
                end
            end
            lot_pkg::OP_REMOVE:
            begin
                if (!here)
                begin
                    p_status = lot_pkg::STS_NOT_PRESENT;
                end
                else
                begin
                    p_unlink = 1'b1;
                end
            end
            lot_pkg::OP_POP:
            begin
                if (count_reg == '0)
                begin
                    p_status = lot_pkg::STS_EMPTY;
                end
                else
                begin
                    p_evict  = 1'b1;
                    p_unlink = 1'b1;
                    p_tgt    = tail_reg;
                end
            end
            default:
            begin
                p_status = lot_pkg::STS_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tgt_reg    <= p_tgt;
            idx_reg    <= in_idx;
            status_reg <= p_status;
            evict_reg  <= p_evict;
            rid_reg    <= p_evict ? ID_W'(tail_reg) : item_id;
            // read both links of the id to be unlinked
            rd_prev_reg <= prev_mem[p_tgt];
            rd_next_reg <= next_mem[p_tgt];
        end
    end

    always_comb
    begin
        present_next = present_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        prev_we      = 1'b0;
        prev_waddr   = rd_next_reg;
        prev_wdata   = rd_prev_reg;
        next_we      = 1'b0;
        next_waddr   = rd_prev_reg;
        next_wdata   = rd_next_reg;
        if (cmd.unlink && plan_unlink_reg)
        begin
            if (count_reg <= cnt_t'(1))
            begin
                head_next = '0;
                tail_next = '0;
            end
            else if (tgt_reg == head_reg)
            begin
                head_next = rd_next_reg;
            end
            else if (tgt_reg == tail_reg)
            begin
                tail_next = rd_prev_reg;
            end
            else
            begin
                // bridge the neighbours over the unlinked id
                next_we = 1'b1;
                prev_we = 1'b1;
            end
            present_next[tgt_reg] = 1'b0;
            count_next            = count_reg - cnt_t'(1);
        end
        if (cmd.link && plan_link_reg)
        begin
            if (count_reg == '0)
            begin
                head_next = idx_reg;
                tail_next = idx_reg;
            end
            else
            begin
                next_we    = 1'b1;
                next_waddr = idx_reg;
                next_wdata = head_reg;
                prev_we    = 1'b1;
                prev_waddr = head_reg;
                prev_wdata = idx_reg;
                head_next  = idx_reg;
            end
            present_next[idx_reg] = 1'b1;
            count_next            = count_reg + cnt_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg     <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            capacity_reg    <= lot_pkg::CAPACITY_RESET;
            plan_unlink_reg <= 1'b0;
            plan_link_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            present_reg <= present_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            if (cmd.capture)
            begin
                plan_unlink_reg <= p_unlink;
                plan_link_reg   <= p_link;
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            status_out_reg  <= status_reg;
            evicted_out_reg <= evict_reg;
            rid_out_reg     <= rid_reg;
            occ_out_reg     <= count_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_out_reg;
    assign evicted   = evicted_out_reg;
    assign result_id = rid_out_reg;
    assign occupancy = occ_out_reg;

    a_count_matches_present: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(present_reg) == int'(count_reg))
        else $error("occupancy count differs from number of present ids");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(NUM_IDS))
        else $error("occupancy count above id space");

    a_empty_ends_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == '0 && tail_reg == '0))
        else $error("empty list with non-zero head or tail");

    a_ends_present: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (present_reg[head_reg] && present_reg[tail_reg]))
        else $error("head or tail of a non-empty list not present");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!out_valid_reg || !out_stall))
        else $error("result register overwritten while stalled");

endmodule
